// File: sv/bea_pkg.sv
// Package for the button edge tracker with auto-repeat.
// Holds transfer layouts, register indexes and reset values; no dependencies.
package bea_pkg;

    localparam int NUM_BUTTONS_DEF = 16;
    localparam int NUM_BUTTONS_MAX = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_DEADZONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_INTERVAL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_AFTER     = 3'd4;

    localparam logic [14:0] DEADZONE_RST        = 15'd16384;
    localparam logic [15:0] REPEAT_DELAY_RST    = 16'd300;
    localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd100;
    localparam logic [15:0] FAST_INTERVAL_RST   = 16'd50;
    localparam logic [15:0] ACCEL_AFTER_RST     = 16'd1000;

    localparam logic [1:0] CMD_FRAME = 2'd0;
    localparam logic [1:0] CMD_EVENT = 2'd1;
    localparam logic [1:0] CMD_AXIS  = 2'd2;
    localparam logic [1:0] CMD_RESET = 2'd3;

    // first member is the top bits: fields listed from the highest bit down
    typedef struct packed {
        logic [31:0]        first_repeat_ms;
        logic [31:0]        now_ms;
        logic signed [15:0] axis_value;
        logic [3:0]         pos_index;
        logic [3:0]         neg_index;
        logic               pressed;
        logic [4:0]         button_index;
        logic [1:0]         cmd;
    } in_item_t;

    typedef struct packed {
        logic [15:0] repeat_mask;
        logic [15:0] new_release_mask;
        logic [15:0] new_press_mask;
        logic [15:0] held_mask;
    } out_item_t;

    localparam int IN_W  = $bits(in_item_t);
    localparam int OUT_W = $bits(out_item_t);

endpackage

// File: sv/button_edge_autorepeat.sv
// Button edge tracker: held/press/release/repeat flags with accelerated auto-repeat.
// Input transfer registered in in_reg, result in out_reg; throughput one item per cycle
// unless m_tready stalls, set by the single-pass update of the per-button state between them.
// Reset (aresetn low, synchronous): flags, hold times and pipeline cleared, registers to defaults;
// repeat times are not cleared and are written by a press before use.
// Depends on bea_pkg.
module button_edge_autorepeat #(
    parameter int NUM_BUTTONS = bea_pkg::NUM_BUTTONS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // cmd, button_index, pressed, neg_index, pos_index, axis_value, now_ms, first_repeat_ms
    input  logic [bea_pkg::IN_W-1:0]         s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // held_mask, new_press_mask, new_release_mask, repeat_mask
    output logic [bea_pkg::OUT_W-1:0]        m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [bea_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [bea_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic [14:0] deadzone_reg;
    logic [15:0] delay_reg;
    logic [15:0] interval_reg;
    logic [15:0] fast_reg;
    logic [15:0] accel_reg;

    bea_pkg::in_item_t  in_reg;
    logic               in_valid_reg;
    bea_pkg::out_item_t out_reg;
    logic               out_valid_reg;
    logic               advance;

    logic [NUM_BUTTONS-1:0] held_reg, press_reg, release_reg, repeat_reg;
    logic [NUM_BUTTONS-1:0] held_next, press_next, release_next, repeat_next;
    logic [31:0] nrt_reg [NUM_BUTTONS];
    logic [31:0] nrt_next [NUM_BUTTONS];
    logic [31:0] hbt_reg [NUM_BUTTONS];
    logic [31:0] hbt_next [NUM_BUTTONS];

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadzone_reg <= bea_pkg::DEADZONE_RST;
            delay_reg    <= bea_pkg::REPEAT_DELAY_RST;
            interval_reg <= bea_pkg::REPEAT_INTERVAL_RST;
            fast_reg     <= bea_pkg::FAST_INTERVAL_RST;
            accel_reg    <= bea_pkg::ACCEL_AFTER_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                bea_pkg::CFG_AXIS_DEADZONE:   deadzone_reg <= cfg_wdata[14:0];
                bea_pkg::CFG_REPEAT_DELAY:    delay_reg    <= cfg_wdata;
                bea_pkg::CFG_REPEAT_INTERVAL: interval_reg <= cfg_wdata;
                bea_pkg::CFG_FAST_INTERVAL:   fast_reg     <= cfg_wdata;
                bea_pkg::CFG_ACCEL_AFTER:     accel_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [NUM_BUTTONS-1:0] bsel, psel, nsel, hit;
        logic signed [16:0]     ax, dz_pos, dz_neg;
        logic [31:0]            due, held_for;

        held_next    = held_reg;
        press_next   = press_reg;
        release_next = release_reg;
        repeat_next  = repeat_reg;
        due          = '0;
        held_for     = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            nrt_next[i] = nrt_reg[i];
            hbt_next[i] = hbt_reg[i];
            bsel[i] = (in_reg.button_index == 5'(i));
            psel[i] = ({1'b0, in_reg.pos_index} == 5'(i));
            nsel[i] = ({1'b0, in_reg.neg_index} == 5'(i));
        end
        ax     = {in_reg.axis_value[15], in_reg.axis_value};
        dz_pos = {2'b00, deadzone_reg};
        dz_neg = -dz_pos;
        hit    = '0;

        case (in_reg.cmd)
            bea_pkg::CMD_FRAME: begin
                press_next   = '0;
                release_next = '0;
                repeat_next  = '0;
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    due      = in_reg.now_ms - nrt_reg[i];
                    held_for = in_reg.now_ms - hbt_reg[i];
                    if (held_reg[i] && !due[31]) begin
                        repeat_next[i] = 1'b1;
                        nrt_next[i] = nrt_reg[i] + ((held_for > 32'(accel_reg))
                            ? 32'(fast_reg) : 32'(interval_reg));
                    end
                end
            end
            bea_pkg::CMD_EVENT: begin
                if (!in_reg.pressed) begin
                    held_next    = held_reg & ~bsel;
                    repeat_next  = repeat_reg & ~bsel;
                    release_next = release_reg | bsel;
                    for (int i = 0; i < NUM_BUTTONS; i++) begin
                        if (bsel[i]) hbt_next[i] = '0;
                    end
                end else begin
                    hit          = bsel & ~held_reg;
                    held_next    = held_reg | hit;
                    press_next   = press_reg | hit;
                    repeat_next  = repeat_reg | hit;
                    for (int i = 0; i < NUM_BUTTONS; i++) begin
                        if (hit[i]) begin
                            nrt_next[i] = in_reg.now_ms + 32'(delay_reg);
                            hbt_next[i] = in_reg.now_ms;
                        end
                    end
                end
            end
            bea_pkg::CMD_AXIS: begin
                if (ax > dz_pos || ax < dz_neg) begin
                    // press one direction; if that press is new, release the opposite one if held
                    hit = (ax > dz_pos) ? (psel & ~held_reg) : (nsel & ~held_reg);
                    held_next   = held_reg | hit;
                    press_next  = press_reg | hit;
                    repeat_next = repeat_reg | hit;
                    for (int i = 0; i < NUM_BUTTONS; i++) begin
                        if (hit[i]) begin
                            nrt_next[i] = in_reg.first_repeat_ms;
                            hbt_next[i] = in_reg.first_repeat_ms - 32'(delay_reg);
                        end
                    end
                    if (hit != '0) begin
                        hit = held_next & ((ax > dz_pos) ? nsel : psel);
                        held_next    = held_next & ~hit;
                        repeat_next  = repeat_next & ~hit;
                        release_next = release_next | hit;
                    end
                end else begin
                    hit          = held_reg & (nsel | psel);
                    held_next    = held_reg & ~hit;
                    repeat_next  = repeat_reg & ~hit;
                    release_next = release_reg | hit;
                end
            end
            default: begin
                held_next    = '0;
                press_next   = '0;
                release_next = '0;
                repeat_next  = '0;
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    hbt_next[i] = '0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
            press_reg     <= '0;
            release_reg   <= '0;
            repeat_reg    <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                hbt_reg[i] <= '0;
            end
        end else begin
            if (s_tvalid && s_tready) begin
                in_reg <= bea_pkg::in_item_t'(s_tdata);
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (in_valid_reg && advance) begin
                held_reg    <= held_next;
                press_reg   <= press_next;
                release_reg <= release_next;
                repeat_reg  <= repeat_next;
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    hbt_reg[i] <= hbt_next[i];
                end
                out_reg.held_mask        <= 16'(held_next);
                out_reg.new_press_mask   <= 16'(press_next);
                out_reg.new_release_mask <= 16'(release_next);
                out_reg.repeat_mask      <= 16'(repeat_next);
            end
        end
    end

    // repeat times have no reset
    always_ff @(posedge aclk) begin
        if (in_valid_reg && advance) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                nrt_reg[i] <= nrt_next[i];
            end
        end
    end

endmodule
